FILE: rtl/tlla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tlla_pkg;

  localparam int unsigned ReqTypeBits = 3;
  localparam int unsigned SlotBits    = 6;
  localparam int unsigned TcBits      = 16;
  localparam int unsigned RndBits     = 32;
  localparam int unsigned StatusBits  = 2;

  typedef enum logic [ReqTypeBits-1:0] {
    REQ_CREATE   = 3'd0,
    REQ_SET_TIX  = 3'd1,
    REQ_SET_RUN  = 3'd2,
    REQ_DRAW     = 3'd3,
    REQ_QUANTUM  = 3'd4
  } req_e;

  localparam logic [StatusBits-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusBits-1:0] STATUS_ZERO    = 2'd1;
  localparam logic [StatusBits-1:0] STATUS_NOTHING = 2'd2;

  typedef struct packed {
    logic [ReqTypeBits-1:0] req_type;
    logic [SlotBits-1:0]    slot;
    logic [TcBits-1:0]      ticket_count;
    logic                   runnable;
    logic [RndBits-1:0]     random_value;
  } req_t;

  typedef struct packed {
    logic                  grant_valid;
    logic [SlotBits-1:0]   grant_slot;
    logic                  give_up;
    logic [StatusBits-1:0] status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_APPLY,
    ST_REFILL,
    ST_CHECK,
    ST_DIV,
    ST_WALK,
    ST_REMOVE,
    ST_RESP
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_step;
    logic load_req;
    logic rd_req_slot;
    logic apply;
    logic refill_start;
    logic refill_step;
    logic div_start;
    logic div_step;
    logic walk_start;
    logic walk_step;
    logic remove;
    logic set_empty;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic is_draw;
    logic refill_done;
    logic sums_zero;
    logic div_done;
    logic walk_hit;
    logic walk_end;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/tlla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tlla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/tlla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tlla_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire tlla_pkg::sts_t sts_i,
  output tlla_pkg::cmd_t     cmd_o
);
  import tlla_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sts_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ:   state_d = ST_APPLY;
      ST_APPLY: begin
        if (sts_i.is_draw) begin
          state_d = sts_i.sums_zero ? ST_REFILL : ST_DIV;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_REFILL: if (sts_i.refill_done) state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.sums_zero ? ST_RESP : ST_DIV;
      ST_DIV:    if (sts_i.div_done) state_d = ST_WALK;
      ST_WALK: begin
        if (sts_i.walk_hit) begin
          state_d = ST_REMOVE;
        end else if (sts_i.walk_end) begin
          state_d = ST_RESP;
        end
      end
      ST_REMOVE: state_d = ST_RESP;
      ST_RESP:   if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_step = 1'b1;
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.load_req   = in_valid_i;
      end
      ST_READ:  cmd_o.rd_req_slot = 1'b1;
      ST_APPLY: begin
        cmd_o.apply        = 1'b1;
        cmd_o.refill_start = sts_i.is_draw && sts_i.sums_zero;
        cmd_o.div_start    = sts_i.is_draw && !sts_i.sums_zero;
      end
      ST_REFILL: cmd_o.refill_step = 1'b1;
      ST_CHECK: begin
        cmd_o.div_start = !sts_i.sums_zero;
        cmd_o.set_empty = sts_i.sums_zero;
      end
      ST_DIV: begin
        cmd_o.div_step   = 1'b1;
        cmd_o.walk_start = sts_i.div_done;
      end
      ST_WALK:   cmd_o.walk_step = 1'b1;
      ST_REMOVE: cmd_o.remove = 1'b1;
      ST_RESP:   out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/tlla_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module tlla_dpath #(
  parameter int unsigned NumSlots   = 64,
  parameter int unsigned TicketBits = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tlla_pkg::req_t req_i,
  input  wire tlla_pkg::cmd_t cmd_i,
  output tlla_pkg::sts_t      sts_o,
  output tlla_pkg::rsp_t      rsp_o
);
  import tlla_pkg::*;

  localparam int unsigned IdxBits = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned SumBits = TicketBits + IdxBits;
  localparam int unsigned CntBits = IdxBits + 1;
  localparam int unsigned DivCntBits = $clog2(RndBits + 1);
  // One memory word per slot: level, runnable, round member, tickets.
  localparam int unsigned WordBits = TicketBits + 3;
  localparam int unsigned RoundPos = TicketBits;
  localparam int unsigned RunPos   = TicketBits + 1;
  localparam int unsigned HighPos  = TicketBits + 2;

  req_t req_q;
  logic in_table_q;

  logic                  tk_we;
  logic [IdxBits-1:0]    tk_waddr, tk_raddr;
  logic [WordBits-1:0]   tk_wdata, tk_rdata;

  logic [SumBits-1:0]  hsum_q, lsum_q;
  logic                half_q;

  logic [CntBits-1:0]  idx_q;
  logic                rd_valid_q;
  logic [IdxBits-1:0]  rd_idx_q;
  logic                level_q;
  logic [SumBits-1:0]  div_rem_q;
  logic [RndBits-1:0]  div_quo_q;
  logic [DivCntBits-1:0] div_cnt_q;
  logic [SumBits-1:0]  acc_q;
  logic [IdxBits-1:0]  win_q;
  rsp_t                rsp_q;

  tlla_ram #(.Width(WordBits), .Depth(NumSlots)) u_tickets (
    .clk_i   (clk_i),
    .we_i    (tk_we),
    .waddr_i (tk_waddr),
    .wdata_i (tk_wdata),
    .raddr_i (tk_raddr),
    .rdata_o (tk_rdata)
  );

  logic [IdxBits-1:0] rq_slot;
  logic [TicketBits-1:0] new_t, cur_t;
  logic cur_high, cur_run, cur_round;
  logic [SumBits-1:0] cur_ext, new_ext;
  assign rq_slot   = IdxBits'(req_q.slot);
  assign new_t     = TicketBits'(req_q.ticket_count);
  assign cur_t     = tk_rdata[TicketBits-1:0];
  assign cur_round = tk_rdata[RoundPos];
  assign cur_run   = tk_rdata[RunPos];
  assign cur_high  = tk_rdata[HighPos];
  assign cur_ext   = SumBits'(cur_t);
  assign new_ext   = SumBits'(new_t);

  logic walk_member, walk_hit, join_ok;
  assign walk_member = rd_valid_q && cur_round && (cur_high == level_q);
  assign walk_hit    = walk_member && (acc_q + cur_ext > div_rem_q);
  assign join_ok     = rd_valid_q && cur_run && (cur_t != '0) && !cur_round;

  // Read address: request slot, or walk/refill index.
  always_comb begin
    if (cmd_i.rd_req_slot) begin
      tk_raddr = rq_slot;
    end else begin
      tk_raddr = idx_q[IdxBits-1:0];
    end
  end

  // Apart from the clear sweep and create, every slot update is a read-modify-write of the word read the cycle before.
  always_comb begin
    tk_we    = 1'b0;
    tk_waddr = rq_slot;
    tk_wdata = tk_rdata;
    if (cmd_i.clear_step) begin
      tk_we    = idx_q < CntBits'(NumSlots);
      tk_waddr = idx_q[IdxBits-1:0];
      tk_wdata = '0;
    end else if (cmd_i.apply && in_table_q) begin
      unique case (req_q.req_type)
        REQ_CREATE: begin
          tk_we    = 1'b1;
          tk_wdata = {1'b1, 1'b1, 1'b0, TicketBits'(1)};
        end
        REQ_SET_TIX: if (new_t != '0) begin
          tk_we    = 1'b1;
          tk_wdata = {cur_high, cur_run, cur_round, new_t};
        end
        REQ_SET_RUN: begin
          tk_we    = 1'b1;
          tk_wdata = {cur_high, req_q.runnable, cur_round && req_q.runnable, cur_t};
        end
        REQ_QUANTUM: if (cur_high) begin
          tk_we    = 1'b1;
          tk_wdata = {1'b0, cur_run, cur_round, cur_t};
        end
        default: ;
      endcase
    end else if (cmd_i.refill_step && join_ok) begin
      tk_we    = 1'b1;
      tk_waddr = rd_idx_q;
      tk_wdata = {cur_high, cur_run, 1'b1, cur_t};
    end else if (cmd_i.walk_step && walk_hit) begin
      tk_we    = 1'b1;
      tk_waddr = rd_idx_q;
      tk_wdata = {cur_high, cur_run, 1'b0, cur_t};
    end
  end

  logic [SumBits:0] div_trial;
  logic [SumBits-1:0] div_sum;
  assign div_sum   = level_q ? hsum_q : lsum_q;
  assign div_trial = {div_rem_q, div_quo_q[RndBits-1]} - {1'b0, div_sum};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q      <= req_i;
      in_table_q <= 32'(req_i.slot) < NumSlots;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsum_q     <= '0;
      lsum_q     <= '0;
      half_q     <= 1'b0;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
      level_q    <= 1'b0;
      div_cnt_q  <= '0;
      win_q      <= '0;
      rsp_q      <= '0;
    end else begin
      if (cmd_i.clear_step && idx_q < CntBits'(NumSlots)) idx_q <= idx_q + 1'b1;
      if (cmd_i.load_req) begin
        rsp_q <= '0;
      end
      if (cmd_i.apply) begin
        unique case (req_q.req_type)
          REQ_CREATE: if (in_table_q && cur_round) begin
            if (cur_high) hsum_q <= hsum_q - cur_ext;
            else lsum_q <= lsum_q - cur_ext;
          end
          REQ_SET_TIX: begin
            if (new_t == '0) begin
              rsp_q.status <= STATUS_ZERO;
            end else if (in_table_q && cur_round) begin
              if (cur_high) hsum_q <= hsum_q - cur_ext + new_ext;
              else lsum_q <= lsum_q - cur_ext + new_ext;
            end
          end
          REQ_SET_RUN: if (in_table_q && !req_q.runnable && cur_round) begin
            if (cur_high) hsum_q <= hsum_q - cur_ext;
            else lsum_q <= lsum_q - cur_ext;
          end
          REQ_QUANTUM: if (in_table_q) begin
            if (cur_high) begin
              if (cur_round) begin
                hsum_q <= hsum_q - cur_ext;
                lsum_q <= lsum_q + cur_ext;
              end
              rsp_q.give_up <= 1'b1;
            end else begin
              half_q        <= !half_q;
              rsp_q.give_up <= half_q;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.refill_start) begin
        idx_q      <= '0;
        rd_valid_q <= 1'b0;
      end
      if (cmd_i.refill_step) begin
        if (idx_q < CntBits'(NumSlots)) idx_q <= idx_q + 1'b1;
        rd_valid_q <= idx_q < CntBits'(NumSlots);
        rd_idx_q   <= idx_q[IdxBits-1:0];
        if (join_ok) begin
          if (cur_high) hsum_q <= hsum_q + cur_ext;
          else lsum_q <= lsum_q + cur_ext;
        end
      end
      if (cmd_i.set_empty) rsp_q.status <= STATUS_NOTHING;
      if (cmd_i.div_start) begin
        level_q   <= hsum_q != '0;
        div_cnt_q <= '0;
      end
      if (cmd_i.div_step) div_cnt_q <= div_cnt_q + 1'b1;
      if (cmd_i.walk_start) begin
        idx_q      <= '0;
        rd_valid_q <= 1'b0;
      end
      if (cmd_i.walk_step) begin
        if (idx_q < CntBits'(NumSlots)) idx_q <= idx_q + 1'b1;
        rd_valid_q <= idx_q < CntBits'(NumSlots);
        rd_idx_q   <= idx_q[IdxBits-1:0];
        // The winner leaves the round as soon as it is found.
        if (walk_hit) begin
          win_q <= rd_idx_q;
          if (level_q) hsum_q <= hsum_q - cur_ext;
          else lsum_q <= lsum_q - cur_ext;
        end
      end
      if (cmd_i.remove) begin
        rsp_q.grant_valid <= 1'b1;
        rsp_q.grant_slot  <= SlotBits'(win_q);
      end
    end
  end

  // Restoring division: one quotient bit per cycle. acc_q is the running
  // ticket sum during the walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_rem_q <= '0;
      div_quo_q <= req_q.random_value;
    end else if (cmd_i.div_step && div_cnt_q < DivCntBits'(RndBits)) begin
      if (!div_trial[SumBits]) div_rem_q <= div_trial[SumBits-1:0];
      else div_rem_q <= {div_rem_q[SumBits-2:0], div_quo_q[RndBits-1]};
      div_quo_q <= {div_quo_q[RndBits-2:0], 1'b0};
    end
    if (cmd_i.walk_start) begin
      acc_q <= '0;
    end else if (cmd_i.walk_step && walk_member) begin
      if (walk_hit) acc_q <= cur_ext;
      else acc_q <= acc_q + cur_ext;
    end
  end

  assign sts_o.clear_done  = rd_valid_q == 1'b0 && idx_q == CntBits'(NumSlots);
  assign sts_o.is_draw     = req_q.req_type == REQ_DRAW;
  assign sts_o.refill_done = rd_valid_q == 1'b0 && idx_q == CntBits'(NumSlots);
  assign sts_o.sums_zero   = hsum_q == '0 && lsum_q == '0;
  assign sts_o.div_done    = div_cnt_q == DivCntBits'(RndBits);
  assign sts_o.walk_hit    = walk_hit;
  assign sts_o.walk_end    = rd_valid_q == 1'b0 && idx_q == CntBits'(NumSlots);
  assign rsp_o             = rsp_q;
endmodule
`default_nettype wire

FILE: rtl/two_level_lottery_arbiter.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-level lottery arbiter. Each request transaction produces exactly one
// response transaction. After reset the block clears its slot table, one
// slot per cycle, and keeps its input stalled until the clear is done.
// Each slot's tickets and its level, runnable and round flags share one word
// of a registered memory, so a request's update is a read followed by a write.
// Create, set and quantum-end requests pass through the read and apply
// states before the response handshake. A draw that finds a nonempty round
// forms the remainder of the random word by the ticket sum of its high
// level, or of its low level when the high one is empty, one bit per cycle,
// then walks the slots one per cycle through the registered memory. A draw
// that must refill the round first sweeps the slot table to rebuild it.
// The block handles one transaction at a time and stalls input meanwhile.
module two_level_lottery_arbiter #(
  parameter int unsigned NUM_SLOTS   = 64,
  parameter int unsigned TICKET_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire tlla_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output tlla_pkg::rsp_t      out_data_o
);
  import tlla_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlla_dpath #(.NumSlots(NUM_SLOTS), .TicketBits(TICKET_BITS)) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_data_o)
  );
endmodule
`default_nettype wire

FILE: rtl/tlla_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tlla_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire tlla_pkg::rsp_t out_data_o
);
  import tlla_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while response pending");

  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.grant_valid |-> !out_data_o.give_up &&
    out_data_o.status == STATUS_OK)
    else $error("grant mixed with other result");

  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("response without processing");
endmodule

bind two_level_lottery_arbiter tlla_checker u_tlla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
